>>> rtl/core/dta_pkg.sv
// Shared widths, types, tables and helper functions of the torsion-angle pipeline.
`timescale 1ns / 1ps
`default_nettype none
package dta_pkg;

  // coordinate and bond vector widths
  localparam int COORD_WIDTH = 24;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;

  // scaled normal and pair widths
  localparam int NORM_BITS = 22;
  localparam int AW = NORM_BITS + 1;
  localparam int ABW = 2 * AW;
  localparam int XW = ABW + 1;
  localparam int PAIR_BITS = 30;
  localparam int QW = PAIR_BITS + 1;
  localparam int AXIS_BITS = 28;
  localparam int EW = AXIS_BITS + 1;
  localparam int SQW = 2 * PAIR_BITS + 2;
  localparam int RB = SQW / 2;
  localparam int DOTW = QW + EW + 2;

  // CORDIC widths
  localparam int CORDIC_STEPS = 22;
  localparam int KW = QW + 4;
  localparam int ZW = 26;
  localparam int ANGLE_W = 17;

  // leading-one search width
  localparam int BLW = (NW > XW) ? NW : XW;
  localparam int LW = $clog2(BLW + 1);

  // stage counts per section
  localparam int N_NRM = 5;
  localparam int N_PAIR = 6;
  localparam int N_SQRT = RB;
  localparam int N_CRD = CORDIC_STEPS + 3;
  localparam int N_STAGES = N_NRM + N_PAIR + N_SQRT + N_CRD;

  // angle constants, 1/65536 degree units (ANGLE_MAX in 1/256 degree)
  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * 65536);
  localparam logic signed [ZW-1:0] ROUND_HALF = ZW'(128);
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(46080);

  // atan(2^-k) in 1/65536 degree
  localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    ZW'(2949120), ZW'(1740967), ZW'(919879), ZW'(466945), ZW'(234379), ZW'(117304),
    ZW'(58666), ZW'(29335), ZW'(14668), ZW'(7334), ZW'(3667), ZW'(1833), ZW'(917),
    ZW'(458), ZW'(229), ZW'(115), ZW'(57), ZW'(29), ZW'(14), ZW'(7), ZW'(4), ZW'(2)
  };

  // cross product index pairs: component i = u[J]v[K] - u[K]v[J]
  localparam int CROSS_J [3] = '{1, 2, 0};
  localparam int CROSS_K [3] = '{2, 0, 1};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic                 dot_pos;
    logic                 degen;
  } side_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      degen;
  } res_t;

  // bit length of an unsigned value (index of leading one plus one)
  function automatic logic [LW-1:0] bit_len(input logic [BLW-1:0] v);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < BLW; i++) begin
      if (v[i]) n = LW'(i + 1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dta_if.sv
// Valid/ready channel interfaces for point items and angle items.
`timescale 1ns / 1ps
`default_nettype none
interface dta_in_if;
  logic            valid;
  logic            ready;
  dta_pkg::coord_t first_x, first_y, first_z;
  dta_pkg::coord_t second_x, second_y, second_z;
  dta_pkg::coord_t third_x, third_y, third_z;
  dta_pkg::coord_t fourth_x, fourth_y, fourth_z;

  modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 third_x, third_y, third_z, fourth_x, fourth_y, fourth_z, input ready);
  modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, fourth_x, fourth_y, fourth_z, output ready);
endinterface

interface dta_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dta_pkg::ANGLE_W-1:0] angle_deg;
  logic                               degenerate;

  modport source(output valid, angle_deg, degenerate, input ready);
  modport sink(input valid, angle_deg, degenerate, output ready);
endinterface
`default_nettype wire

>>> rtl/core/dihedral_angle_four_points.sv
// Top level of the four-point torsion angle pipeline with output skid buffer.
//
//  channel   dir  handshake     payload
//  in_pts    in   valid/ready   first..fourth _x/_y/_z, 24-bit signed Q13.10
//  out_res   out  valid/ready   angle_deg (17-bit signed, 1/256 deg), degenerate
//
// One item per cycle unless the output stalls; 67 pipeline stages plus the
// output register. The 31-stage square root and 22 CORDIC rotation stages set
// the depth. Reset clears only the valid bits. A stalled output fills the skid
// register first, then the whole pipeline holds; no item is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module dihedral_angle_four_points (
  input var logic   clk,
  input var logic   rst_n,
  dta_in_if.sink    in_pts,
  dta_out_if.source out_res
);
  localparam int NST = dta_pkg::N_STAGES;
  localparam int AW = dta_pkg::AW;
  localparam int EW = dta_pkg::EW;
  localparam int SQW = dta_pkg::SQW;
  localparam int RB = dta_pkg::RB;

  logic en;
  dta_pkg::coord_t pts [12];

  always_comb begin
    pts[0] = in_pts.first_x;   pts[1] = in_pts.first_y;   pts[2] = in_pts.first_z;
    pts[3] = in_pts.second_x;  pts[4] = in_pts.second_y;  pts[5] = in_pts.second_z;
    pts[6] = in_pts.third_x;   pts[7] = in_pts.third_y;   pts[8] = in_pts.third_z;
    pts[9] = in_pts.fourth_x;  pts[10] = in_pts.fourth_y; pts[11] = in_pts.fourth_z;
  end

  // datapath sections
  logic signed [AW-1:0] a_w [3], b_w [3];
  logic signed [EW-1:0] d2s_w [3];
  logic                 dg_w;
  logic [SQW-1:0]       sq_w;
  dta_pkg::side_t       side_p, side_s;
  logic [RB-1:0]        root_w;
  dta_pkg::res_t        pres;

  dta_normals u_nrm (
    .clk(clk), .en(en), .pts(pts), .a_o(a_w), .b_o(b_w), .d2s_o(d2s_w), .degen_o(dg_w)
  );
  dta_pair u_pair (
    .clk(clk), .en(en), .a_i(a_w), .b_i(b_w), .d2s_i(d2s_w), .degen_i(dg_w),
    .sq_o(sq_w), .side_o(side_p)
  );
  dta_isqrt u_sqrt (
    .clk(clk), .en(en), .sq_i(sq_w), .side_i(side_p), .root_o(root_w), .side_o(side_s)
  );
  dta_cordic u_crd (
    .clk(clk), .en(en), .root_i(root_w), .side_i(side_s), .res_o(pres)
  );

  // valid bits beside the data, output register and skid register
  logic [NST-1:0] v_r, v_nxt;
  logic           out_v_r, out_v_nxt, sk_v_r, sk_v_nxt;
  dta_pkg::res_t  out_d_r, out_d_nxt, sk_d_r, sk_d_nxt;
  logic           take;

  assign en = !sk_v_r;
  assign take = out_v_r && out_res.ready;

  always_comb begin
    v_nxt = en ? {v_r[NST-2:0], in_pts.valid} : v_r;
    out_v_nxt = out_v_r;
    sk_v_nxt = sk_v_r;
    out_d_nxt = out_d_r;
    sk_d_nxt = sk_d_r;
    if (en) begin
      if (v_r[NST-1] && (!out_v_r || out_res.ready)) begin
        out_v_nxt = 1'b1;
        out_d_nxt = pres;
      end else if (v_r[NST-1]) begin
        sk_v_nxt = 1'b1;
        sk_d_nxt = pres;
      end else if (take) begin
        out_v_nxt = 1'b0;
      end
    end else if (take) begin
      out_d_nxt = sk_d_r;
      sk_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_v_r <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
      out_v_r <= out_v_nxt;
      sk_v_r <= sk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
    sk_d_r <= sk_d_nxt;
  end

  assign in_pts.ready = en;
  assign out_res.valid = out_v_r;
  assign out_res.angle_deg = out_d_r.angle;
  assign out_res.degenerate = out_d_r.degen;

  // checks
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_d_r.degen |-> out_d_r.angle == '0)
    else $error("degenerate item with nonzero angle");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid holds an item while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_res.ready))
    else $error("skid filled without an output stall");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_d_r.angle <= dta_pkg::ANGLE_MAX && out_d_r.angle >= -dta_pkg::ANGLE_MAX))
    else $error("angle out of range");
endmodule
`default_nettype wire

>>> rtl/core/dta_normals.sv
// Bond vectors, exact plane normals and their scaling to 22-bit magnitude.
`timescale 1ns / 1ps
`default_nettype none
module dta_normals (
  input  var logic            clk,
  input  var logic            en,
  input  var dta_pkg::coord_t pts [12],
  output logic signed [dta_pkg::AW-1:0] a_o [3],
  output logic signed [dta_pkg::AW-1:0] b_o [3],
  output logic signed [dta_pkg::EW-1:0] d2s_o [3],
  output logic                          degen_o
);
  localparam int DW = dta_pkg::DW;
  localparam int PW = dta_pkg::PW;
  localparam int NW = dta_pkg::NW;
  localparam int AW = dta_pkg::AW;
  localparam int EW = dta_pkg::EW;
  localparam int LW = dta_pkg::LW;
  localparam int BLW = dta_pkg::BLW;

  // stage 1: bond vectors
  logic signed [DW-1:0] d1_r [3], d2_r [3], d3_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= DW'(pts[i]) - DW'(pts[3+i]);
        d2_r[i] <= DW'(pts[3+i]) - DW'(pts[6+i]);
        d3_r[i] <= DW'(pts[9+i]) - DW'(pts[6+i]);
      end
    end
  end

  // stage 2: cross product terms, d2 scale amount
  logic signed [PW-1:0] pa_nxt [2][3], pb_nxt [2][3], pa_r [2][3], pb_r [2][3];
  logic signed [DW-1:0] d2c_r [3];
  logic [DW-1:0]        d2m [3];
  logic [LW-1:0]        d2l, es_nxt, es_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_nxt[0][i] = PW'(d1_r[dta_pkg::CROSS_J[i]]) * PW'(d2_r[dta_pkg::CROSS_K[i]]);
      pb_nxt[0][i] = PW'(d1_r[dta_pkg::CROSS_K[i]]) * PW'(d2_r[dta_pkg::CROSS_J[i]]);
      pa_nxt[1][i] = PW'(d3_r[dta_pkg::CROSS_J[i]]) * PW'(d2_r[dta_pkg::CROSS_K[i]]);
      pb_nxt[1][i] = PW'(d3_r[dta_pkg::CROSS_K[i]]) * PW'(d2_r[dta_pkg::CROSS_J[i]]);
      d2m[i] = d2_r[i][DW-1] ? DW'(-d2_r[i]) : DW'(d2_r[i]);
    end
    d2l = dta_pkg::bit_len(BLW'(d2m[0] | d2m[1] | d2m[2]));
    es_nxt = (d2l > LW'(dta_pkg::AXIS_BITS)) ? d2l - LW'(dta_pkg::AXIS_BITS) : '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      d2c_r <= d2_r;
      es_r <= es_nxt;
    end
  end

  // stage 3: normal components, d2 truncated toward zero
  logic signed [NW-1:0] n_r [2][3];
  logic signed [EW-1:0] d2s_nxt [3], d2s3_r [3], d2s4_r [3];
  logic [DW-1:0]        d2cm [3], d2sh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2cm[i] = d2c_r[i][DW-1] ? DW'(-d2c_r[i]) : DW'(d2c_r[i]);
      d2sh[i] = d2cm[i] >> es_r;
      d2s_nxt[i] = d2c_r[i][DW-1] ? EW'(-$signed({1'b0, d2sh[i]}))
                                  : EW'($signed({1'b0, d2sh[i]}));
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int q = 0; q < 2; q++) begin
        for (int i = 0; i < 3; i++) begin
          n_r[q][i] <= NW'(pa_r[q][i]) - NW'(pb_r[q][i]);
        end
      end
      d2s3_r <= d2s_nxt;
    end
  end

  // stage 4: magnitudes and shared shift per normal
  logic [NW-1:0] mag_nxt [2][3], mag_r [2][3];
  logic          neg_r [2][3];
  logic [LW-1:0] nl [2], ns_nxt [2], ns_r [2];
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      for (int i = 0; i < 3; i++) begin
        mag_nxt[q][i] = n_r[q][i][NW-1] ? NW'(-n_r[q][i]) : NW'(n_r[q][i]);
      end
      nl[q] = dta_pkg::bit_len(BLW'(mag_nxt[q][0] | mag_nxt[q][1] | mag_nxt[q][2]));
      ns_nxt[q] = (nl[q] > LW'(dta_pkg::NORM_BITS)) ? nl[q] - LW'(dta_pkg::NORM_BITS) : '0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      ns_r <= ns_nxt;
      for (int q = 0; q < 2; q++) begin
        for (int i = 0; i < 3; i++) neg_r[q][i] <= n_r[q][i][NW-1];
      end
      d2s4_r <= d2s3_r;
    end
  end

  // stage 5: scaled normals and zero-normal flag
  logic [NW-1:0]        sh [2][3];
  logic signed [AW-1:0] sv [2][3];
  logic                 zr [2];
  always_comb begin
    for (int q = 0; q < 2; q++) begin
      zr[q] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        sh[q][i] = mag_r[q][i] >> ns_r[q];
        sv[q][i] = $signed(AW'(sh[q][i]));
        if (neg_r[q][i]) sv[q][i] = -sv[q][i];
        if (sh[q][i] != '0) zr[q] = 1'b0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_o <= sv[0];
      b_o <= sv[1];
      d2s_o <= d2s4_r;
      degen_o <= zr[0] | zr[1];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/dta_pair.sv
// Cross and dot of the scaled normals, pair scaling, squared sine term and sign test.
`timescale 1ns / 1ps
`default_nettype none
module dta_pair (
  input  var logic                          clk,
  input  var logic                          en,
  input  var logic signed [dta_pkg::AW-1:0] a_i [3],
  input  var logic signed [dta_pkg::AW-1:0] b_i [3],
  input  var logic signed [dta_pkg::EW-1:0] d2s_i [3],
  input  var logic                          degen_i,
  output logic [dta_pkg::SQW-1:0]           sq_o,
  output dta_pkg::side_t                    side_o
);
  localparam int ABW = dta_pkg::ABW;
  localparam int XW = dta_pkg::XW;
  localparam int QW = dta_pkg::QW;
  localparam int EW = dta_pkg::EW;
  localparam int SQW = dta_pkg::SQW;
  localparam int DOTW = dta_pkg::DOTW;
  localparam int LW = dta_pkg::LW;
  localparam int BLW = dta_pkg::BLW;
  localparam int SW = 2 * dta_pkg::PAIR_BITS;

  // pipeline-carried d2 and flag
  logic signed [EW-1:0] d2_r [4][3];
  logic                 dg_r [5];

  // stage 6: nine partial products
  logic signed [ABW-1:0] pr_r [9];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_r[2*i]   <= ABW'(a_i[dta_pkg::CROSS_J[i]]) * ABW'(b_i[dta_pkg::CROSS_K[i]]);
        pr_r[2*i+1] <= ABW'(a_i[dta_pkg::CROSS_K[i]]) * ABW'(b_i[dta_pkg::CROSS_J[i]]);
        pr_r[6+i]   <= ABW'(a_i[i]) * ABW'(b_i[i]);
      end
      d2_r[0] <= d2s_i;
      dg_r[0] <= degen_i;
    end
  end

  // stage 7: c = a x b (entries 0..2) and x = a . b (entry 3)
  logic signed [XW-1:0] c_r [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) c_r[i] <= XW'(pr_r[2*i]) - XW'(pr_r[2*i+1]);
      c_r[3] <= XW'(pr_r[6]) + XW'(pr_r[7]) + XW'(pr_r[8]);
      d2_r[1] <= d2_r[0];
      dg_r[1] <= dg_r[0];
    end
  end

  // stage 8: magnitudes and shared shift
  logic [XW-1:0] m_nxt [4], m_r [4];
  logic          ng_r [4];
  logic [LW-1:0] cl, s_nxt, s_r;
  always_comb begin
    for (int i = 0; i < 4; i++) m_nxt[i] = c_r[i][XW-1] ? XW'(-c_r[i]) : XW'(c_r[i]);
    cl = dta_pkg::bit_len(BLW'(m_nxt[0] | m_nxt[1] | m_nxt[2] | m_nxt[3]));
    s_nxt = (cl > LW'(dta_pkg::PAIR_BITS)) ? cl - LW'(dta_pkg::PAIR_BITS) : '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
      s_r <= s_nxt;
      for (int i = 0; i < 4; i++) ng_r[i] <= c_r[i][XW-1];
      d2_r[2] <= d2_r[1];
      dg_r[2] <= dg_r[1];
    end
  end

  // stage 9: truncate toward zero
  logic [XW-1:0]        msh [4];
  logic signed [QW-1:0] q_nxt [4], q_r [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      msh[i] = m_r[i] >> s_r;
      q_nxt[i] = $signed(QW'(msh[i]));
      if (ng_r[i]) q_nxt[i] = -q_nxt[i];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
      d2_r[3] <= d2_r[2];
      dg_r[3] <= dg_r[2];
    end
  end

  // stage 10: squares of c and c * d2 terms
  logic signed [2*QW-1:0] sqp [3];
  logic [SW-1:0]          sq_r [3];
  logic signed [DOTW-1:0] dp_r [3];
  logic signed [QW-1:0]   x10_r;
  always_comb begin
    for (int i = 0; i < 3; i++) sqp[i] = (2*QW)'(q_r[i]) * (2*QW)'(q_r[i]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sqp[i][SW-1:0];
        dp_r[i] <= DOTW'(q_r[i]) * DOTW'(d2_r[3][i]);
      end
      x10_r <= q_r[3];
      dg_r[4] <= dg_r[3];
    end
  end

  // stage 11: sums and sign test
  logic signed [DOTW-1:0] dot;
  always_comb dot = dp_r[0] + dp_r[1] + dp_r[2];
  always_ff @(posedge clk) begin
    if (en) begin
      sq_o <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      side_o.x <= x10_r;
      side_o.dot_pos <= !dot[DOTW-1] && (dot != '0);
      side_o.degen <= dg_r[4];
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/dta_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module dta_isqrt (
  input  var logic                     clk,
  input  var logic                     en,
  input  var logic [dta_pkg::SQW-1:0]  sq_i,
  input  var dta_pkg::side_t           side_i,
  output logic [dta_pkg::RB-1:0]       root_o,
  output dta_pkg::side_t               side_o
);
  localparam int SQW = dta_pkg::SQW;
  localparam int RB = dta_pkg::RB;

  logic [SQW-1:0] v_r [RB];
  logic [SQW-1:0] r_r [RB];
  dta_pkg::side_t sd_r [RB];

  for (genvar j = 0; j < RB; j++) begin : g_step
    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * (RB - 1 - j));
    logic [SQW-1:0] v_in, r_in;
    dta_pkg::side_t s_in;
    logic [SQW:0]   t;

    if (j == 0) begin : g_first
      assign v_in = sq_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_r[j-1];
      assign r_in = r_r[j-1];
      assign s_in = sd_r[j-1];
    end

    // trial subtract of r + bit
    always_comb t = {1'b0, r_in} + {1'b0, BITV};
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[j] <= s_in;
        if ({1'b0, v_in} >= t) begin
          v_r[j] <= v_in - t[SQW-1:0];
          r_r[j] <= (r_in >> 1) + BITV;
        end else begin
          v_r[j] <= v_in;
          r_r[j] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_r[RB-1][RB-1:0];
  assign side_o = sd_r[RB-1];
endmodule
`default_nettype wire

>>> rtl/core/dta_cordic.sv
// Normalize, fold to the right half plane, CORDIC vectoring, round and apply sign.
`timescale 1ns / 1ps
`default_nettype none
module dta_cordic (
  input  var logic                    clk,
  input  var logic                    en,
  input  var logic [dta_pkg::RB-1:0]  root_i,
  input  var dta_pkg::side_t          side_i,
  output dta_pkg::res_t               res_o
);
  localparam int QW = dta_pkg::QW;
  localparam int RB = dta_pkg::RB;
  localparam int KW = dta_pkg::KW;
  localparam int ZW = dta_pkg::ZW;
  localparam int LW = dta_pkg::LW;
  localparam int BLW = dta_pkg::BLW;
  localparam int ANGLE_W = dta_pkg::ANGLE_W;
  localparam int NSTEP = dta_pkg::CORDIC_STEPS;

  // stage C0: doubling count so max(|x|, y) reaches 2^29
  logic [QW-1:0]        mx;
  logic [LW-1:0]        pl, sh_nxt, sh_r;
  logic signed [QW-1:0] x0_r;
  logic [RB-1:0]        y0_r;
  logic                 dp0_r, dg0_r;
  always_comb begin
    mx = side_i.x[QW-1] ? QW'(-side_i.x) : QW'(side_i.x);
    pl = dta_pkg::bit_len(BLW'(mx) | BLW'(root_i));
    sh_nxt = (pl < LW'(dta_pkg::PAIR_BITS)) ? LW'(dta_pkg::PAIR_BITS) - pl : '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= side_i.x;
      y0_r <= root_i;
      sh_r <= sh_nxt;
      dp0_r <= side_i.dot_pos;
      dg0_r <= side_i.degen;
    end
  end

  // stage C1: scale and rotate by -90 degrees when x is negative
  logic signed [KW-1:0] xs, ys;
  logic signed [KW-1:0] kx_r [NSTEP+1], ky_r [NSTEP+1];
  logic signed [ZW-1:0] kz_r [NSTEP+1];
  logic                 kp_r [NSTEP+1], kd_r [NSTEP+1];
  always_comb begin
    xs = KW'(x0_r) <<< sh_r;
    ys = $signed(KW'({1'b0, y0_r})) <<< sh_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (xs[KW-1]) begin
        kx_r[0] <= ys;
        ky_r[0] <= -xs;
        kz_r[0] <= dta_pkg::DEG90;
      end else begin
        kx_r[0] <= xs;
        ky_r[0] <= ys;
        kz_r[0] <= '0;
      end
      kp_r[0] <= dp0_r;
      kd_r[0] <= dg0_r;
    end
  end

  // CORDIC vectoring, one micro-rotation per stage
  for (genvar k = 0; k < NSTEP; k++) begin : g_rot
    logic signed [KW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    always_comb begin
      dx = ky_r[k] >>> k;
      dy = kx_r[k] >>> k;
      at = $signed(dta_pkg::ATAN_TAB[k]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        kp_r[k+1] <= kp_r[k];
        kd_r[k+1] <= kd_r[k];
        if (ky_r[k] > 0) begin
          kx_r[k+1] <= kx_r[k] + dx;
          ky_r[k+1] <= ky_r[k] - dy;
          kz_r[k+1] <= kz_r[k] + at;
        end else if (ky_r[k] < 0) begin
          kx_r[k+1] <= kx_r[k] - dx;
          ky_r[k+1] <= ky_r[k] + dy;
          kz_r[k+1] <= kz_r[k] - at;
        end else begin
          kx_r[k+1] <= kx_r[k];
          ky_r[k+1] <= ky_r[k];
          kz_r[k+1] <= kz_r[k];
        end
      end
    end
  end

  // final stage: clamp to 0..180, round half up to 1/256 degree, sign, zero if degenerate
  logic signed [ZW-1:0]      tc, rs;
  logic signed [ANGLE_W-1:0] ang;
  always_comb begin
    tc = kz_r[NSTEP];
    if (tc < 0) tc = '0;
    if (tc > dta_pkg::DEG180) tc = dta_pkg::DEG180;
    rs = tc + dta_pkg::ROUND_HALF;
    ang = $signed(rs[ANGLE_W+7:8]);
    if (kp_r[NSTEP]) ang = -ang;
    if (kd_r[NSTEP]) ang = '0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      res_o.angle <= ang;
      res_o.degen <= kd_r[NSTEP];
    end
  end
endmodule
`default_nettype wire
